// ===== rtl/tdp_pkg.sv =====
package tdp_pkg;

	localparam int WIDTH = 32;
	localparam int NUMBER_W = 32;
	localparam int EXT_W = (WIDTH > NUMBER_W) ? WIDTH : NUMBER_W;
	localparam int CNT_W = $clog2(WIDTH + 1);

	localparam logic [WIDTH-1:0] FIRST_DIVISOR = WIDTH'(3);
	localparam logic [WIDTH-1:0] DIVISOR_STEP = WIDTH'(2);
	localparam logic [WIDTH-1:0] SMALLEST_PRIME = WIDTH'(2);

	typedef struct packed {
		logic             start;
		logic [WIDTH-1:0] dividend;
		logic [WIDTH-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [WIDTH-1:0] quo;
		logic [WIDTH-1:0] rem;
	} div_res_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_START = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

endpackage

// ===== rtl/trial_division_prime_test.sv =====
// Primality test by trial division. One number is taken per beat and one prime flag
// comes back. Numbers below 2 and all even numbers, 2 included, are decided at once:
// they go straight to ST_DONE, and prime_valid rises from there when the output
// register is free. Odd numbers of 3 or more go through a single bit-serial restoring
// divider, which yields quotient and remainder together for each odd divisor 3, 5, 7
// and so on, and stops once the divisor exceeds the quotient or a remainder is zero;
// for each divisor the divider is loaded in ST_START and its result awaited in ST_WAIT.
// The input is stalled while a number is in work; the finished flag sits in an output
// register, so the next number is accepted while it waits to be taken.
module trial_division_prime_test (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [tdp_pkg::NUMBER_W-1:0] number,
	input  logic                         number_valid,
	output logic                         number_stall,
	output logic                         prime,
	output logic                         prime_valid,
	input  logic                         prime_stall
);

	tdp_pkg::state_t   state_q;
	tdp_pkg::div_req_t div_req;
	tdp_pkg::div_res_t div_res;

	logic [tdp_pkg::WIDTH-1:0] n_q;
	logic [tdp_pkg::WIDTH-1:0] d_q;
	logic                      res_q;
	logic                      prime_q;
	logic                      prime_valid_q;

	logic [tdp_pkg::EXT_W-1:0] num_ext;
	logic [tdp_pkg::WIDTH-1:0] n_in;
	logic                      accept;
	logic                      out_free;
	logic                      out_load;

	assign num_ext  = tdp_pkg::EXT_W'(number);
	assign n_in     = num_ext[tdp_pkg::WIDTH-1:0];
	assign accept   = number_valid && !number_stall;
	assign out_free = !prime_valid_q || !prime_stall;
	assign out_load = (state_q == tdp_pkg::ST_DONE) && out_free;

	assign div_req.start    = (state_q == tdp_pkg::ST_START);
	assign div_req.dividend = n_q;
	assign div_req.divisor  = d_q;

	tdp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= tdp_pkg::ST_IDLE;
			prime_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				prime_valid_q <= 1'b1;
			end else if (prime_valid_q && !prime_stall) begin
				prime_valid_q <= 1'b0;
			end
			unique case (state_q)
				tdp_pkg::ST_IDLE: begin
					if (accept) begin
						if (n_in[tdp_pkg::WIDTH-1:1] == '0 || n_in == tdp_pkg::SMALLEST_PRIME
								|| !n_in[0]) begin
							state_q <= tdp_pkg::ST_DONE;
						end else begin
							state_q <= tdp_pkg::ST_START;
						end
					end
				end
				tdp_pkg::ST_START: begin
					state_q <= tdp_pkg::ST_WAIT;
				end
				tdp_pkg::ST_WAIT: begin
					if (div_res.done) begin
						if (d_q > div_res.quo || div_res.rem == '0) begin
							state_q <= tdp_pkg::ST_DONE;
						end else begin
							state_q <= tdp_pkg::ST_START;
						end
					end
				end
				tdp_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= tdp_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tdp_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tdp_pkg::ST_IDLE && accept) begin
			n_q   <= n_in;
			d_q   <= tdp_pkg::FIRST_DIVISOR;
			res_q <= (n_in == tdp_pkg::SMALLEST_PRIME);
		end
		if (state_q == tdp_pkg::ST_WAIT && div_res.done) begin
			if (d_q > div_res.quo) begin
				res_q <= 1'b1;
			end else if (div_res.rem == '0) begin
				res_q <= 1'b0;
			end else begin
				d_q <= d_q + tdp_pkg::DIVISOR_STEP;
			end
		end
		if (out_load) begin
			prime_q <= res_q;
		end
	end

	assign number_stall = (state_q != tdp_pkg::ST_IDLE);
	assign prime        = prime_q;
	assign prime_valid  = prime_valid_q;

endmodule

// ===== rtl/tdp_div.sv =====
module tdp_div (
	input  logic             clk,
	input  logic             arst_n,
	input  tdp_pkg::div_req_t req,
	output tdp_pkg::div_res_t res
);

	logic [tdp_pkg::WIDTH-1:0] rem_q;
	logic [tdp_pkg::WIDTH-1:0] quo_q;
	logic [tdp_pkg::WIDTH-1:0] dsr_q;
	logic [tdp_pkg::CNT_W-1:0] cnt_q;
	logic                      busy_q;
	logic                      done_q;

	logic [tdp_pkg::WIDTH:0] trial;
	logic [tdp_pkg::WIDTH:0] diff;

	assign trial = {rem_q, quo_q[tdp_pkg::WIDTH-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= tdp_pkg::CNT_W'(tdp_pkg::WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tdp_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[tdp_pkg::WIDTH]) begin
				rem_q <= diff[tdp_pkg::WIDTH-1:0];
			end else begin
				rem_q <= trial[tdp_pkg::WIDTH-1:0];
			end
			quo_q <= {quo_q[tdp_pkg::WIDTH-2:0], ~diff[tdp_pkg::WIDTH]};
		end
	end

	assign res.done = done_q;
	assign res.quo  = quo_q;
	assign res.rem  = rem_q;

endmodule

// ===== rtl/tdp_checker.sv =====
module tdp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic [tdp_pkg::NUMBER_W-1:0] number,
	input logic                         number_valid,
	input logic                         number_stall,
	input logic                         prime,
	input logic                         prime_valid,
	input logic                         prime_stall
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		prime_valid && prime_stall |=> prime_valid && $stable(prime))
		else $error("stalled result beat changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		number_valid && !number_stall |=> number_stall)
		else $error("input taken while a number is in work");

	a_zero_not_prime: assert property (@(posedge clk) disable iff (!arst_n)
		number_valid && !number_stall && !prime_valid && number == '0
		|=> ##1 prime_valid && !prime)
		else $error("zero not reported composite in time");

	a_two_prime: assert property (@(posedge clk) disable iff (!arst_n)
		number_valid && !number_stall && !prime_valid
		&& number == tdp_pkg::NUMBER_W'(2)
		|=> ##1 prime_valid && prime)
		else $error("two not reported prime in time");

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.number       (number),
	.number_valid (number_valid),
	.number_stall (number_stall),
	.prime        (prime),
	.prime_valid  (prime_valid),
	.prime_stall  (prime_stall)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int RANDOM_ITEMS = 100;
	localparam int DRAIN_CYCLES = 16;
	localparam longint CYCLE_LIMIT = 20_000_000;
	localparam longint unsigned WIDTH_MASK = {64{1'b1}} >> (64 - tdp_pkg::WIDTH);

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic [tdp_pkg::NUMBER_W-1:0] number = '0;
	logic                         number_valid = 1'b0;
	logic                         number_stall;
	logic                         prime;
	logic                         prime_valid;
	logic                         prime_stall = 1'b0;

	logic [tdp_pkg::NUMBER_W-1:0] pending_numbers[$];
	logic                         prime_flags_due[$];
	int                           mismatches = 0;
	int                           burst_left = 1;
	int                           gap_left = 0;
	int unsigned                  stall_cnt = 0;
	longint                       cycles = 0;

	trial_division_prime_test u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.number       (number),
		.number_valid (number_valid),
		.number_stall (number_stall),
		.prime        (prime),
		.prime_valid  (prime_valid),
		.prime_stall  (prime_stall)
	);

	function automatic logic prime_of(logic [tdp_pkg::NUMBER_W-1:0] n);
		longint unsigned v;
		longint unsigned d;
		v = n;
		v = v & WIDTH_MASK;
		if (v < 2)
			return 1'b0;
		if (v == 2)
			return 1'b1;
		if (v % 2 == 0)
			return 1'b0;
		for (d = 3; d <= v / d; d += 2)
			if (v % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// driver: bursts of beats with random gaps, payload held while stalled
	always @(posedge clk) begin
		if (arst_n) begin
			if (number_valid && !number_stall)
				prime_flags_due.push_back(prime_of(number));
			if (!number_valid || !number_stall) begin
				if (gap_left > 0) begin
					number_valid <= 1'b0;
					gap_left--;
				end else if (pending_numbers.size() > 0) begin
					number <= pending_numbers.pop_front();
					number_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 8);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					number_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result beat with the oldest pending flag
	always @(posedge clk) begin
		if (arst_n) begin
			if (prime_valid && !prime_stall) begin
				if (prime_flags_due.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual prime=%0b",
						$realtime, prime);
					mismatches++;
				end else begin
					logic want;
					want = prime_flags_due.pop_front();
					if (prime !== want) begin
						$display("%0t: prime mismatch, expected %0b, actual %0b",
							$realtime, want, prime);
						mismatches++;
					end
				end
			end
			stall_cnt++;
			case (stall_cnt[9:8])
				2'd0: prime_stall <= 1'b0;
				2'd1: prime_stall <= $urandom_range(0, 1);
				2'd2: prime_stall <= (stall_cnt[2:0] < 3'd3);
				default: prime_stall <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	initial begin
		logic [31:0] n;
		logic [31:0] f;
		int unsigned bits;
		int unsigned pick;
		int i;

		foreach (pending_numbers[j])
			pending_numbers.delete(j);
		pending_numbers.push_back(32'd0);
		pending_numbers.push_back(32'd1);
		pending_numbers.push_back(32'd2);
		pending_numbers.push_back(32'd3);
		pending_numbers.push_back(32'd4);
		pending_numbers.push_back(32'd5);
		pending_numbers.push_back(32'd9);
		pending_numbers.push_back(32'd15);
		pending_numbers.push_back(32'd25);
		pending_numbers.push_back(32'd49);
		pending_numbers.push_back(32'd65521);
		pending_numbers.push_back(32'd1042441);
		pending_numbers.push_back(32'hFFFF_FFFF);
		pending_numbers.push_back(32'hFFFF_FFFE);
		pending_numbers.push_back(32'h8000_0000);
		pending_numbers.push_back(32'hAAAA_AAAB);
		pending_numbers.push_back(32'd4294967291);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				bits = $urandom_range(1, 18);
				n = $urandom & ((32'd1 << bits) - 32'd1);
			end else if (pick < 65) begin
				n = $urandom & ~32'd1;
			end else if (pick < 85) begin
				f = 2 * $urandom_range(1, 49) + 1;
				n = f * $urandom_range(1, 32'hFFFF_FFFF / f);
			end else begin
				bits = $urandom_range(19, 24);
				n = ($urandom & ((32'd1 << bits) - 32'd1)) | 32'd1;
			end
			pending_numbers.push_back(n);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_numbers.size() == 0 && !number_valid);
		wait (prime_flags_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
